// ===== sv/sliding_window_max_assert.svh =====
// assertion macros shared by the sliding window max block
`ifndef SLIDING_WINDOW_MAX_ASSERT_SVH
`define SLIDING_WINDOW_MAX_ASSERT_SVH

// condition must hold in the same cycle
`define SWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sliding_window_max: same-cycle check failed");

// condition must hold in the next cycle
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sliding_window_max: next-cycle check failed");

`endif

// ===== sv/swm_pkg.sv =====
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int LEN_W       = 7;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int FILL_W      = $clog2(WINDOW_MAX + 1);
    // position tags only need to resolve ages up to WINDOW_MAX
    localparam int POS_W       = $clog2(WINDOW_MAX + 1) + 1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample            value;
        logic [POS_W-1:0]   pos;
    } t_entry;

    // request from the sequencer to the queue store
    typedef struct packed {
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        t_entry             wr_data;
    } t_mem_req;

    // circular slot at head + offset
    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                               input logic [FILL_W-1:0] off);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(head) + (FILL_W+1)'(off);
        if (s >= (FILL_W+1)'(WINDOW_MAX)) begin
            s = s - (FILL_W+1)'(WINDOW_MAX);
        end
        return s[ADDR_W-1:0];
    endfunction

    // window length limited to 1 .. WINDOW_MAX
    function automatic logic [FILL_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [FILL_W-1:0] r;
        if (len == '0) begin
            r = FILL_W'(1);
        end else if (LEN_W'(len) > LEN_W'(WINDOW_MAX)) begin
            r = FILL_W'(WINDOW_MAX);
        end else begin
            r = FILL_W'(len);
        end
        return r;
    endfunction

endpackage

// ===== sv/swm_if.sv =====
interface swm_in_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] window_len;

    modport source (output valid, output window_len, input ready);
    modport sink   (input valid, input window_len, output ready);
endinterface

// ===== sv/swm_store.sv =====
module swm_store import swm_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [WINDOW_MAX];
    t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/swm_seq.sv =====
module swm_seq import swm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_sample          i_sample,
    input  logic             i_restart,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output t_sample          o_window_max,
    input  logic [LEN_W-1:0] i_window_len,
    output t_mem_req         o_req,
    input  t_entry           i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BACK_RD,
        S_BACK_CHK,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [FILL_W-1:0] r_seen, n_seen;
    logic [FILL_W-1:0] r_len, n_len;
    t_sample           r_sample, n_sample;
    t_sample           r_front, n_front;
    logic              r_out_valid, n_out_valid;
    t_sample           r_out_data, n_out_data;

    logic              in_req;
    logic [FILL_W-1:0] seen_next;
    logic              has_result;
    logic [POS_W-1:0]  age;

    assign in_req     = i_in_valid && (r_state == S_IDLE);
    assign seen_next  = (r_seen < FILL_W'(WINDOW_MAX)) ? r_seen + FILL_W'(1) : r_seen;
    assign has_result = (seen_next >= r_len);
    assign age        = r_pos - i_rd_data.pos;

    // next state and memory requests
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_len       = r_len;
        n_sample    = r_sample;
        n_front     = r_front;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        o_req.rd_en   = 1'b0;
        o_req.rd_addr = r_head;
        o_req.wr_en   = 1'b0;
        o_req.wr_addr = slot(r_head, r_fill);
        o_req.wr_data = '{value: r_sample, pos: r_pos};

        case (r_state)
            S_IDLE: begin
                if (in_req) begin
                    n_sample = i_sample;
                    n_len    = clamp_len(i_window_len);
                    if (i_restart) begin
                        n_head = '0;
                        n_fill = '0;
                        n_pos  = '0;
                        n_seen = '0;
                    end
                    n_state = S_BACK_RD;
                end
            end
            // pop back entries the new sample equals or exceeds
            S_BACK_RD: begin
                if (r_fill == '0) begin
                    n_state = S_FRONT_RD;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = slot(r_head, r_fill - FILL_W'(1));
                    n_state       = S_BACK_CHK;
                end
            end
            S_BACK_CHK: begin
                if (r_sample >= i_rd_data.value) begin
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = S_BACK_RD;
                end else begin
                    n_state = S_FRONT_RD;
                end
            end
            // drop front entries that left the window
            S_FRONT_RD: begin
                if (r_fill == '0) begin
                    n_front = r_sample;
                    n_state = S_PUSH;
                end else begin
                    o_req.rd_en   = 1'b1;
                    o_req.rd_addr = r_head;
                    n_state       = S_FRONT_CHK;
                end
            end
            S_FRONT_CHK: begin
                if (FILL_W'(age) >= r_len) begin
                    n_head  = slot(r_head, FILL_W'(1));
                    n_fill  = r_fill - FILL_W'(1);
                    n_state = S_FRONT_RD;
                end else begin
                    n_front = i_rd_data.value;
                    n_state = S_PUSH;
                end
            end
            // append the sample, emit the front once the window is full
            S_PUSH: begin
                if (!(has_result && r_out_valid && !i_out_ready)) begin
                    o_req.wr_en = 1'b1;
                    n_fill      = r_fill + FILL_W'(1);
                    n_pos       = r_pos + POS_W'(1);
                    n_seen      = seen_next;
                    if (has_result) begin
                        n_out_valid = 1'b1;
                        n_out_data  = r_front;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_seen      <= '0;
            r_len       <= FILL_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_sample   <= n_sample;
        r_front    <= n_front;
        r_out_data <= n_out_data;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

endmodule

// ===== sv/sliding_window_max.sv =====
// an accepted sample is checked against queue entries from the back, then from the front,
//   one read state and one check state per entry examined (at most one check that keeps each),
//   then pushed with its result registered; a new sample is taken only after that push, which
//   waits while an earlier result is not yet taken; the walk uses the single store read port
// reset: synchronous, queue empty, position and count zero, window_len back to 1;
//   the queue store is not cleared and needs no clearing pass
`include "sliding_window_max_assert.svh"

module sliding_window_max import swm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swm_in_if.sink       i_in,
    swm_out_if.source    o_out,
    swm_cfg_if.sink      i_cfg
);

    logic [LEN_W-1:0] r_window_len;
    t_mem_req         mem_req;
    t_entry           rd_data;

    // window length register, always writable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= LEN_W'(1);
        end else if (i_cfg.valid) begin
            r_window_len <= i_cfg.window_len;
        end
    end

    assign i_cfg.ready = 1'b1;

    // queue sequencer
    swm_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_sample     (i_in.sample),
        .i_restart    (i_in.restart),
        .o_in_ready   (i_in.ready),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_window_max (o_out.window_max),
        .i_window_len (r_window_len),
        .o_req        (mem_req),
        .i_rd_data    (rd_data)
    );

    // queue value and position store
    swm_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // one sample in flight at a time
    `SWM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // store never read and written in the same cycle
    `SWM_ASSERT_SAME(a_no_rw_overlap, i_clk, i_rst_n, mem_req.wr_en, !mem_req.rd_en)
    // a new result always comes with the push of its sample
    `SWM_ASSERT_SAME(a_result_on_push, i_clk, i_rst_n, $rose(o_out.valid), $past(mem_req.wr_en))

endmodule
